/* design/bsfd_pkg.sv */
// Shared types and constants for the byte stream frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package bsfd_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE   = 4'd1;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    // The length field never spans more than four bytes.
    localparam int unsigned LEN_IDX_W = 2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_MODE = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       link_fault;
    } item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [7:0]  frame_mode;
        logic [31:0] frame_length;
    } result_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } cfg_t;

endpackage

`default_nettype wire

/* design/bsfd_parser.sv */
// Input register and frame parsing state machine of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module bsfd_parser
    import bsfd_pkg::*;
#(
    parameter int unsigned START_CODE_BYTES = 4,
    parameter int unsigned END_CODE_BYTES   = 4,
    parameter int unsigned LENGTH_BYTES     = 4
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    input  wire logic    full,
    output logic         push,
    output result_t      push_data
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_reg;
    logic    accept, advance;

    phase_t               phase_reg, phase_next;
    logic [2:0]           match_reg, match_next;
    logic [7:0]           mode_reg, mode_next;
    logic [31:0]          length_reg, length_next;
    logic [LEN_IDX_W-1:0] lidx_reg, lidx_next;
    logic [31:0]          remain_reg, remain_next;

    logic [2:0]  match_inc;
    logic [2:0]  lidx_inc;
    logic [31:0] len_lane;
    logic [31:0] len_merged;
    logic [31:0] remain_dec;
    logic        emit;
    logic [1:0]  emit_kind;
    logic [7:0]  emit_byte;
    logic [7:0]  b;

    // The input register moves on whenever the result buffer has room.
    assign advance    = in_valid_reg && !full;
    assign item_stall = in_valid_reg && full;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    assign b          = in_reg.rx_byte;
    assign match_inc  = match_reg + 3'd1;
    assign lidx_inc   = {1'b0, lidx_reg} + 3'd1;
    assign remain_dec = remain_reg - 32'd1;

    always_comb
    begin
        case (lidx_reg)
            2'd0:    len_lane = {24'd0, b};
            2'd1:    len_lane = {16'd0, b, 8'd0};
            2'd2:    len_lane = {8'd0, b, 16'd0};
            default: len_lane = {b, 24'd0};
        endcase
    end

    assign len_merged = length_reg | len_lane;

    always_comb
    begin
        phase_next  = phase_reg;
        match_next  = match_reg;
        mode_next   = mode_reg;
        length_next = length_reg;
        lidx_next   = lidx_reg;
        remain_next = remain_reg;
        emit        = 1'b0;
        emit_kind   = KIND_PAYLOAD;
        emit_byte   = 8'd0;

        if (in_reg.link_fault)
        begin
            // A fault abandons any frame; while hunting it only clears the run.
            match_next = 3'd0;
            phase_next = PH_HUNT;
            if (phase_reg == PH_MODE || phase_reg == PH_LEN ||
                phase_reg == PH_DATA || phase_reg == PH_END)
            begin
                emit      = 1'b1;
                emit_kind = KIND_DROP;
            end
        end
        else
        begin
            case (phase_reg)
                PH_MODE:
                begin
                    mode_next   = b;
                    length_next = 32'd0;
                    lidx_next   = '0;
                    phase_next  = PH_LEN;
                end
                PH_LEN:
                begin
                    length_next = len_merged;
                    if (lidx_inc >= 3'(LENGTH_BYTES))
                    begin
                        lidx_next   = '0;
                        remain_next = len_merged;
                        match_next  = 3'd0;
                        phase_next  = (len_merged == 32'd0) ? PH_END : PH_DATA;
                    end
                    else
                    begin
                        lidx_next = lidx_inc[LEN_IDX_W-1:0];
                    end
                end
                PH_DATA:
                begin
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        match_next = 3'd0;
                        phase_next = PH_END;
                    end
                    emit      = 1'b1;
                    emit_kind = KIND_PAYLOAD;
                    emit_byte = b;
                end
                PH_END:
                begin
                    if (b != cfg.end_byte)
                    begin
                        match_next = 3'd0;
                        phase_next = PH_HUNT;
                        emit       = 1'b1;
                        emit_kind  = KIND_DROP;
                    end
                    else if (match_inc >= 3'(END_CODE_BYTES))
                    begin
                        match_next = 3'd0;
                        phase_next = PH_HUNT;
                        emit       = 1'b1;
                        emit_kind  = KIND_DONE;
                    end
                    else
                    begin
                        match_next = match_inc;
                    end
                end
                default:
                begin
                    // Hunting, and any code that means nothing is treated so.
                    phase_next = PH_HUNT;
                    if (b != cfg.start_byte)
                    begin
                        match_next = 3'd0;
                    end
                    else if (match_inc >= 3'(START_CODE_BYTES))
                    begin
                        match_next  = 3'd0;
                        mode_next   = 8'd0;
                        length_next = 32'd0;
                        lidx_next   = '0;
                        remain_next = 32'd0;
                        phase_next  = PH_MODE;
                    end
                    else
                    begin
                        match_next = match_inc;
                    end
                end
            endcase
        end
    end

    assign push                   = advance && emit;
    assign push_data.out_kind     = emit_kind;
    assign push_data.out_byte     = emit_byte;
    assign push_data.frame_mode   = mode_next;
    assign push_data.frame_length = length_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HUNT;
            match_reg    <= 3'd0;
            mode_reg     <= 8'd0;
            length_reg   <= 32'd0;
            lidx_reg     <= '0;
            remain_reg   <= 32'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                phase_reg  <= phase_next;
                match_reg  <= match_next;
                mode_reg   <= mode_next;
                length_reg <= length_next;
                lidx_reg   <= lidx_next;
                remain_reg <= remain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
    end

endmodule

`default_nettype wire

/* design/bsfd_out_buf.sv */
// Two-entry result buffer that decouples the parser from output stalls.
`timescale 1ns / 1ps
`default_nettype none

module bsfd_out_buf
    import bsfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full         = (count_reg == 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result       = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* design/byte_stream_frame_deframer_unit.sv */
// Top level of the byte stream frame deframer.
// A result passes from the input register through the two-entry result buffer
// before it is presented at the result port.
// Throughput: one request per cycle while the result buffer is not full; the parse step
// lies between the input register and the two-entry result buffer.
// Reset: asynchronous, active low; the parser hunts for a start code, both
// delimiter bytes read zero and the result buffer is empty.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_frame_deframer_unit
    import bsfd_pkg::*;
#(
    parameter int unsigned START_CODE_BYTES = 4,
    parameter int unsigned END_CODE_BYTES   = 4,
    parameter int unsigned LENGTH_BYTES     = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire item_t                  item,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output result_t                     result
);

    // The delimiter registers accept a write in any cycle. Writes to an
    // index outside the register list are taken and have no effect.
    cfg_t    cfg_reg;
    logic    push;
    result_t push_data;
    logic    full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_BYTE: cfg_reg.start_byte <= cfg_data;
                REG_END_BYTE:   cfg_reg.end_byte   <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // The parser holds each request in its input register until the result buffer has
    // room and updates the frame state as it moves on. It stalls the input only when
    // its register is occupied and the result buffer is full.
    bsfd_parser #(
        .START_CODE_BYTES (START_CODE_BYTES),
        .END_CODE_BYTES   (END_CODE_BYTES),
        .LENGTH_BYTES     (LENGTH_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .full       (full),
        .push       (push),
        .push_data  (push_data)
    );

    // Two entries let a result wait at the port while the next one is made.
    bsfd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

/* design/bsfd_checker.sv */
// Port-level assertions for the deframer and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bsfd_checker
    import bsfd_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    cfg_ready,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // Only payload results carry a byte.
    a_byte_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_kind != KIND_PAYLOAD |-> result.out_byte == 8'd0)
        else $error("non-payload result carries a byte");

    // No result kind beyond the three defined ones.
    a_kind_defined: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_kind == KIND_PAYLOAD ||
                          result.out_kind == KIND_DONE ||
                          result.out_kind == KIND_DROP))
        else $error("undefined result kind");

    // A stalled result stays and does not change.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // The configuration port never refuses a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind byte_stream_frame_deframer_unit bsfd_checker u_bsfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

/* bench/tb_byte_stream_frame_deframer_unit.sv */
// Self-checking testbench for the byte stream frame deframer: random framed traffic, scoreboard.
`timescale 1ns / 1ps

module tb_byte_stream_frame_deframer_unit;
    import bsfd_pkg::*;

    // Frame geometry, kept equal to the parameters handed to the block.
    localparam int NUM_START_BYTES = 4;
    localparam int NUM_END_BYTES   = 4;
    localparam int NUM_LEN_BYTES   = 4;

    // An index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'hF;

    // A result passes through the input register and the result buffer, so
    // waiting DRAIN_CYCLES after the last expected result is enough to know
    // the block is quiet.
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 220;
    localparam int RANDOM_PHASES = 7;

    // Ways in which a generated frame may be cut short or corrupted.
    typedef enum {
        FRAME_CLEAN,
        CUT_AT_MODE,
        CUT_IN_LENGTH,
        CUT_IN_PAYLOAD,
        CUT_IN_END,
        BAD_END_BYTE
    } frame_flaw_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [7:0]             cfg_data     = '0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;

    // Requests waiting to be offered, and results the block still owes us.
    item_t   pending_items[$];
    result_t expected_results[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int queued_items   = 0;

    // Set at every rising edge when the offered request was taken, so that
    // the driver knows at the following falling edge whether to move on.
    bit offer_taken = 1'b0;

    // The initial block bumps the ticket to ask for one long receiver hold-off.
    int hold_ticket = 0;

    // Our own copy of the deframer: delimiter settings and parse state.
    logic [7:0]  start_delim = '0;
    logic [7:0]  end_delim   = '0;
    phase_t      ph          = PH_HUNT;
    logic [2:0]  run_count   = '0;
    logic [7:0]  mode_q      = '0;
    logic [31:0] len_q       = '0;
    logic [1:0]  len_idx     = '0;
    logic [31:0] remaining   = '0;

    byte_stream_frame_deframer_unit #(
        .START_CODE_BYTES(NUM_START_BYTES),
        .END_CODE_BYTES  (NUM_END_BYTES),
        .LENGTH_BYTES    (NUM_LEN_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always #2 clk = ~clk;

    // Every result carries the mode and declared length of the frame in
    // progress; only a payload result carries a data byte.
    function automatic result_t frame_result(input logic [1:0] kind, input logic [7:0] b);
        result_t res;
        res.out_kind     = kind;
        res.out_byte     = (kind == KIND_PAYLOAD) ? b : 8'h00;
        res.frame_mode   = mode_q;
        res.frame_length = len_q;
        return res;
    endfunction

    // Advances the parse state by one accepted request and tells whether it
    // produces a result.
    function automatic bit deframe_byte(input item_t it, output result_t res);
        bit fire;
        fire = 1'b0;
        res  = '0;
        if (it.link_fault) begin
            // A fault abandons any frame; while hunting it only clears the run.
            if (ph != PH_HUNT) begin
                res  = frame_result(KIND_DROP, 8'h00);
                fire = 1'b1;
            end
            ph        = PH_HUNT;
            run_count = '0;
        end else begin
            case (ph)
                PH_MODE: begin
                    mode_q  = it.rx_byte;
                    len_q   = '0;
                    len_idx = '0;
                    ph      = PH_LEN;
                end
                PH_LEN: begin
                    // The length arrives least significant byte first.
                    len_q = len_q | (32'(it.rx_byte) << (8 * len_idx));
                    if (int'(len_idx) + 1 >= NUM_LEN_BYTES) begin
                        len_idx   = '0;
                        remaining = len_q;
                        run_count = '0;
                        ph        = (len_q == 32'd0) ? PH_END : PH_DATA;
                    end else begin
                        len_idx = len_idx + 2'd1;
                    end
                end
                PH_DATA: begin
                    remaining = remaining - 32'd1;
                    if (remaining == 32'd0) begin
                        run_count = '0;
                        ph        = PH_END;
                    end
                    res  = frame_result(KIND_PAYLOAD, it.rx_byte);
                    fire = 1'b1;
                end
                PH_END: begin
                    if (it.rx_byte != end_delim) begin
                        ph        = PH_HUNT;
                        run_count = '0;
                        res       = frame_result(KIND_DROP, 8'h00);
                        fire      = 1'b1;
                    end else begin
                        run_count = run_count + 3'd1;
                        if (int'(run_count) >= NUM_END_BYTES) begin
                            ph        = PH_HUNT;
                            run_count = '0;
                            res       = frame_result(KIND_DONE, 8'h00);
                            fire      = 1'b1;
                        end
                    end
                end
                default: begin
                    // Hunting: any other byte breaks the run and is not
                    // itself taken as the first byte of a new one.
                    if (it.rx_byte != start_delim) begin
                        run_count = '0;
                    end else begin
                        run_count = run_count + 3'd1;
                        if (int'(run_count) >= NUM_START_BYTES) begin
                            run_count = '0;
                            mode_q    = '0;
                            len_q     = '0;
                            len_idx   = '0;
                            remaining = '0;
                            ph        = PH_MODE;
                        end
                    end
                end
            endcase
        end
        return fire;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 30) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic push_item(input logic [7:0] b, input logic fault);
        item_t it;
        it.rx_byte    = b;
        it.link_fault = fault;
        pending_items.push_back(it);
        queued_items++;
    endtask

    task automatic push_fault();
        push_item(8'($urandom), 1'b1);
    endtask

    // Builds one frame around the current delimiters, optionally broken at
    // a random point inside the flawed section.
    task automatic add_frame(input logic [7:0] mode, input logic [31:0] len,
                             input frame_flaw_t flaw);
        int cut;
        int n_data;
        for (int i = 0; i < NUM_START_BYTES; i++) begin
            push_item(start_delim, 1'b0);
        end
        if (flaw == CUT_AT_MODE) begin
            push_fault();
            return;
        end
        push_item(mode, 1'b0);
        if (flaw == CUT_IN_LENGTH) begin
            cut = $urandom_range(0, NUM_LEN_BYTES - 1);
            for (int i = 0; i < cut; i++) begin
                push_item(len[8*i +: 8], 1'b0);
            end
            push_fault();
            return;
        end
        for (int i = 0; i < NUM_LEN_BYTES; i++) begin
            push_item(len[8*i +: 8], 1'b0);
        end
        if (flaw == CUT_IN_PAYLOAD && len != 32'd0) begin
            n_data = $urandom_range(0, (len > 32'd17) ? 16 : int'(len) - 1);
            for (int i = 0; i < n_data; i++) begin
                push_item(8'($urandom), 1'b0);
            end
            push_fault();
            return;
        end
        for (longint i = 0; i < longint'(len); i++) begin
            push_item(8'($urandom), 1'b0);
        end
        cut = $urandom_range(0, NUM_END_BYTES - 1);
        case (flaw)
            CUT_IN_END, CUT_IN_PAYLOAD: begin
                for (int i = 0; i < cut; i++) begin
                    push_item(end_delim, 1'b0);
                end
                push_fault();
            end
            BAD_END_BYTE: begin
                for (int i = 0; i < cut; i++) begin
                    push_item(end_delim, 1'b0);
                end
                push_item(end_delim ^ (8'd1 << $urandom_range(0, 7)), 1'b0);
            end
            default: begin
                for (int i = 0; i < NUM_END_BYTES; i++) begin
                    push_item(end_delim, 1'b0);
                end
            end
        endcase
    endtask

    // Mostly well-formed frames with random content, with line noise,
    // broken start runs, faults and bad end codes mixed in.
    task automatic add_random_frame();
        int          pick;
        int          n_noise;
        logic [31:0] len;
        frame_flaw_t flaw;
        if ($urandom_range(0, 9) < 3) begin
            n_noise = $urandom_range(1, 5);
            for (int i = 0; i < n_noise; i++) begin
                pick = $urandom_range(0, 3);
                if (pick == 0) begin
                    push_fault();
                end else if (pick == 1) begin
                    push_item(start_delim, 1'b0);
                end else begin
                    push_item(8'($urandom), 1'b0);
                end
            end
            // Close the noise with a byte that breaks any partial start run.
            push_item(start_delim ^ (8'd1 << $urandom_range(0, 7)), 1'b0);
        end

        pick = $urandom_range(0, 99);
        flaw = FRAME_CLEAN;
        if (pick < 10) begin
            len = 32'd0;
        end else if (pick < 70) begin
            len = $urandom_range(1, 8);
        end else if (pick < 88) begin
            len = $urandom_range(9, 40);
        end else if (pick < 94) begin
            len = $urandom_range(41, 120);
        end else begin
            // A huge declared length can only end in a fault mid-payload.
            len  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
            flaw = CUT_IN_PAYLOAD;
        end

        if (flaw == FRAME_CLEAN) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                flaw = FRAME_CLEAN;
            end else if (pick < 75) begin
                flaw = CUT_AT_MODE;
            end else if (pick < 81) begin
                flaw = CUT_IN_LENGTH;
            end else if (pick < 87) begin
                flaw = CUT_IN_PAYLOAD;
            end else if (pick < 93) begin
                flaw = CUT_IN_END;
            end else begin
                flaw = BAD_END_BYTE;
            end
        end
        add_frame(8'($urandom), len, flaw);
    endtask

    // One register write; the block takes it when valid meets ready.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_delims(input logic [7:0] s, input logic [7:0] e);
        write_reg(REG_START_BYTE, s);
        write_reg(REG_END_BYTE, e);
    endtask

    // Blocks until every request is in and every result is out, then lets
    // the pipeline settle, since the last requests may have made no result.
    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Request driver: takes the next pending request at a falling edge once
    // the previous one was taken, working in bursts with random gaps.
    always @(negedge clk) begin : request_driver
        int burst_left;
        int gap_left;
        if (item_valid && !offer_taken) begin
            // The block has not taken the offered request yet: hold it.
        end else if (gap_left > 0) begin
            gap_left--;
            item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            item       <= pending_items.pop_front();
            item_valid <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                // Now and then a long burst with no gaps at all.
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                         : $urandom_range(1, 3);
            end
        end else begin
            item_valid <= 1'b0;
        end
    end

    // Result receiver: stalls in segments of varying density, and holds off
    // for a long stretch whenever the stimulus asks for it.
    always @(negedge clk) begin : result_receiver
        int   hold_served;
        int   hold_left;
        int   seg_left;
        int   stall_mode;
        logic s;
        if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            s = 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(16, 160);
                stall_mode = $urandom_range(0, 3);
            end
            seg_left--;
            case (stall_mode)
                0:       s = 1'b0;
                1:       s = ($urandom_range(0, 3) == 0);
                2:       s = ($urandom_range(0, 3) != 0);
                default: s = ~result_stall;
            endcase
        end
        result_stall <= s;
    end

    // Monitor: checks each accepted result against the oldest prediction,
    // then tracks register writes and accepted requests. Checking first keeps
    // the outcome independent of process order within the edge.
    always @(posedge clk) begin : monitor
        result_t want;
        result_t got;
        offer_taken = item_valid && !item_stall;
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                got = result;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d", got.out_kind));
                end else begin
                    want = expected_results.pop_front();
                    if (got.out_kind !== want.out_kind) begin
                        report_mismatch($sformatf("out_kind %0d, expected %0d",
                                                  got.out_kind, want.out_kind));
                    end
                    if (got.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  got.out_byte, want.out_byte));
                    end
                    if (got.frame_mode !== want.frame_mode) begin
                        report_mismatch($sformatf("frame_mode %02h, expected %02h",
                                                  got.frame_mode, want.frame_mode));
                    end
                    if (got.frame_length !== want.frame_length) begin
                        report_mismatch($sformatf("frame_length %08h, expected %08h",
                                                  got.frame_length, want.frame_length));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_BYTE: start_delim = cfg_data;
                    REG_END_BYTE:   end_delim   = cfg_data;
                    default:        ;
                endcase
            end
            if (item_valid && !item_stall) begin
                if (deframe_byte(item, want)) begin
                    expected_results.push_back(want);
                end
            end
        end
    end

    // Watchdog for a hung or silent block.
    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] s;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests with both delimiters at their reset value of zero:
        // a fault while hunting, a start run broken by an all-ones byte, a
        // zero-length frame that goes straight to the end code, and a fault
        // right after the start code, which drops with mode and length zero.
        push_fault();
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        add_frame(8'hFF, 32'd0, FRAME_CLEAN);
        add_frame(8'h5A, 32'd0, CUT_AT_MODE);
        wait_idle();

        // Random traffic under a series of delimiter settings, extremes first.
        // Each phase ends with the sender paused until every result is in.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            s = 8'($urandom);
            case (p)
                0:       set_delims(8'hFF, 8'hFF);
                1:       set_delims(8'h00, 8'hFF);
                2:       set_delims(8'hFF, 8'h00);
                3:       set_delims(8'hA5, 8'h5A);
                4:       set_delims(s, s);
                default: set_delims(8'($urandom), 8'($urandom));
            endcase
            if (p == 3) begin
                // A write to an unmapped index must leave both delimiters alone.
                write_reg(REG_SPARE, 8'($urandom));
            end
            queued_items = 0;
            while (queued_items < PHASE_ITEMS) begin
                add_random_frame();
            end
            wait_idle();
        end

        // Back-pressure: the receiver holds off for a long stretch while a
        // long payload keeps coming, so the result buffer fills and the block
        // has to stall its input.
        set_delims(8'h3C, 8'hC3);
        hold_ticket++;
        add_frame(8'($urandom), 32'd320, FRAME_CLEAN);
        repeat (4) add_random_frame();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
design/bsfd_pkg.sv
design/bsfd_parser.sv
design/bsfd_out_buf.sv
design/byte_stream_frame_deframer_unit.sv
design/bsfd_checker.sv
bench/tb_byte_stream_frame_deframer_unit.sv
